/* rtl/core/window_layer_table_hit_test_top_defines.svh */
// assertion macros for the window layer table hit test block
// no dependencies; included by the top level
`ifndef WINDOW_LAYER_TABLE_HIT_TEST_TOP_DEFINES_SVH
`define WINDOW_LAYER_TABLE_HIT_TEST_TOP_DEFINES_SVH
`ifndef SYNTH
`define WLTH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wlth check failed");
`define WLTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wlth check failed");
`else
`define WLTH_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WLTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/wlth_pkg.sv */
// shared types and constants for the window layer table hit test block
// no dependencies
package wlth_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int CNT_W        = 7;   // holds a count of up to 127 windows
    localparam int CFG_IDX_W    = 2;
    localparam int CLOSE_MARGIN = 4;

    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_FOCUS   = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TITLEBAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE    = 2'd1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} t_state;

    // command seen by every cell, held for the whole scan
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] w;
        logic [15:0] h;
        logic        cl;
        logic        commit;
        logic [7:0]  new_level;
        logic [31:0] new_id;
    } t_cmd;

    // running scan record handed from cell to cell
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [3:0]       slot;
        logic [7:0]       lvl;
        logic [31:0]      id;
        logic [15:0]      left;
        logic [15:0]      top;
        logic [15:0]      width;
        logic             cl;
        logic             free;
        logic [3:0]       free_slot;
        logic [7:0]       max_lvl;
        logic [CNT_W-1:0] count;
    } t_scan;

endpackage

/* rtl/core/wlth_in_if.sv */
// input word channel of the window layer table hit test block
// no dependencies
interface wlth_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] width;
    logic [15:0] height;
    logic        closable;

    modport source (output valid, mode, slot, pos_x, pos_y, width, height, closable,
                    input ready);
    modport sink   (input valid, mode, slot, pos_x, pos_y, width, height, closable,
                    output ready);
endinterface

/* rtl/core/wlth_out_if.sv */
// result word channel of the window layer table hit test block
// no dependencies
interface wlth_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic [31:0] window_id;
    logic [7:0]  level;
    logic        on_titlebar;
    logic        on_close_button;
    logic [4:0]  window_count;

    modport source (output valid, status, result_slot, window_id, level, on_titlebar,
                    on_close_button, window_count, input ready);
    modport sink   (input valid, status, result_slot, window_id, level, on_titlebar,
                    on_close_button, window_count, output ready);
endinterface

/* rtl/core/wlth_cfg_if.sv */
// configuration write channel of the window layer table hit test block
// no dependencies
interface wlth_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/wlth_cell.sv */
// one window slot: holds its rectangle, level and id, folds itself into the scan record
// depends on wlth_pkg
module wlth_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wlth_pkg::t_cmd  i_cmd,
    input  wlth_pkg::t_scan i_rec,
    output wlth_pkg::t_scan o_rec
);
    import wlth_pkg::*;

    logic        r_used;
    logic        r_claim;
    logic [15:0] r_left;
    logic [15:0] r_top;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [7:0]  r_lvl;
    logic [31:0] r_id;
    logic        r_cl;
    t_scan       r_rec;
    t_scan       n_rec;

    logic       w_tgt;
    logic       w_hold;
    logic       w_match;
    logic       w_first;
    logic [3:0] w_idx;

    assign w_idx = IDX[3:0];
    // slots at 16 and above can never be named by the 4-bit slot field
    assign w_tgt = (IDX < 16) && (i_cmd.slot == w_idx);

    assign w_hold = r_used
        && ({1'b0, i_cmd.px} >= {1'b0, r_left})
        && ({1'b0, i_cmd.px} <  ({1'b0, r_left} + {1'b0, r_width}))
        && ({1'b0, i_cmd.py} >= {1'b0, r_top})
        && ({1'b0, i_cmd.py} <  ({1'b0, r_top} + {1'b0, r_height}));

    always_comb begin
        case (i_cmd.mode)
            MODE_QUERY:   w_match = w_hold && (!i_rec.hit || (r_lvl > i_rec.lvl));
            MODE_DESTROY: w_match = r_used && w_tgt;
            MODE_FOCUS:   w_match = r_used && w_tgt;
            default:      w_match = 1'b0;
        endcase
        w_first = (i_cmd.mode == MODE_CREATE) && !r_used && !i_rec.free;

        n_rec = i_rec;
        // record valid is dropped while reset is held
        n_rec.vld = i_rec.vld && i_rst_n;
        if (r_used) begin
            n_rec.count = i_rec.count + CNT_W'(1);
            if (r_lvl > i_rec.max_lvl) begin
                n_rec.max_lvl = r_lvl;
            end
        end
        if (w_match) begin
            n_rec.hit   = 1'b1;
            n_rec.slot  = w_idx;
            n_rec.lvl   = r_lvl;
            n_rec.id    = r_id;
            n_rec.left  = r_left;
            n_rec.top   = r_top;
            n_rec.width = r_width;
            n_rec.cl    = r_cl;
        end
        if (w_first) begin
            n_rec.free      = 1'b1;
            n_rec.free_slot = w_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_claim   <= 1'b0;
        end else begin
            if (i_rec.vld) begin
                r_claim <= w_first;
            end
            if (i_cmd.commit) begin
                case (i_cmd.mode)
                    MODE_CREATE: begin
                        if (r_claim) begin
                            r_used <= 1'b1;
                        end
                    end
                    MODE_DESTROY: begin
                        if (w_tgt) begin
                            r_used <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload side, no reset
    always_ff @(posedge i_clk) begin
        r_rec.vld       <= n_rec.vld;
        r_rec.hit       <= n_rec.hit;
        r_rec.slot      <= n_rec.slot;
        r_rec.lvl       <= n_rec.lvl;
        r_rec.id        <= n_rec.id;
        r_rec.left      <= n_rec.left;
        r_rec.top       <= n_rec.top;
        r_rec.width     <= n_rec.width;
        r_rec.cl        <= n_rec.cl;
        r_rec.free      <= n_rec.free;
        r_rec.free_slot <= n_rec.free_slot;
        r_rec.max_lvl   <= n_rec.max_lvl;
        r_rec.count     <= n_rec.count;
        if (i_cmd.commit) begin
            if ((i_cmd.mode == MODE_CREATE) && r_claim) begin
                r_left   <= i_cmd.px;
                r_top    <= i_cmd.py;
                r_width  <= i_cmd.w;
                r_height <= i_cmd.h;
                r_cl     <= i_cmd.cl;
                r_lvl    <= i_cmd.new_level;
                r_id     <= i_cmd.new_id;
            end else if ((i_cmd.mode == MODE_FOCUS) && w_tgt) begin
                r_lvl <= i_cmd.new_level;
            end
        end
    end

    assign o_rec = r_rec;

endmodule

/* rtl/core/window_layer_table_hit_test_top.sv */
// top level of the window layer table hit test block: sequencer, config and result logic
// depends on wlth_pkg, the three channel interfaces, wlth_cell and the defines header
`include "window_layer_table_hit_test_top_defines.svh"

// Window table of SLOTS slots built as a row of cells. Every command (create, destroy,
// focus, point query) sends one scan record down the row, one cell per clock, which
// gathers the lowest free slot, the largest used level, the used count and the chosen
// window; at the end of the row the result is formed and the table is updated in the
// same clock. A word passes the r_go register and then the register of every cell in
// the row before its result is registered and shown valid, and the next word is taken
// once the result has been read. Configuration writes are accepted at any time but
// should only be issued while the block is idle.
module window_layer_table_hit_test_top #(
    parameter int SLOTS = wlth_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlth_in_if.sink     i_in,
    wlth_out_if.source  o_out,
    wlth_cfg_if.sink    i_cfg
);
    import wlth_pkg::*;

    t_state r_state;
    t_state n_state;

    logic        r_go;
    logic [1:0]  r_mode;
    logic [3:0]  r_slot;
    logic [15:0] r_px;
    logic [15:0] r_py;
    logic [15:0] r_w;
    logic [15:0] r_h;
    logic        r_cl;
    logic [31:0] r_next_id;
    logic [7:0]  r_tbh;
    logic [7:0]  r_cbs;

    logic [1:0]  r_status;
    logic [3:0]  r_rslot;
    logic [31:0] r_id;
    logic [7:0]  r_lvl;
    logic        r_tb;
    logic        r_cb;
    logic [4:0]  r_count;

    t_cmd  w_cmd;
    t_scan w_seed;
    t_scan w_rec [SLOTS+1];
    t_scan w_last;

    logic             w_accept;
    logic             w_done;
    logic             w_ok;
    logic [1:0]       w_status;
    logic [3:0]       w_rslot;
    logic [31:0]      w_id;
    logic [7:0]       w_lvl;
    logic [7:0]       w_raise;
    logic [CNT_W-1:0] w_count;
    logic             w_tb;
    logic             w_cb;

    logic signed [9:0]  w_diff;
    logic signed [9:0]  w_off;
    logic signed [19:0] w_bx;
    logic signed [19:0] w_by;
    logic signed [19:0] w_x;
    logic signed [19:0] w_y;
    logic signed [19:0] w_cs;
    logic               w_in_x;

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_last      = w_rec[SLOTS];
    assign w_done      = (r_state == S_SCAN) && w_last.vld;
    assign w_raise     = w_last.max_lvl + 8'd1;

    always_comb begin
        w_seed     = '0;
        w_seed.vld = r_go;
    end
    assign w_rec[0] = w_seed;

    generate
        for (genvar g = 0; g < SLOTS; g++) begin : g_cell
            wlth_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_rec   (w_rec[g]),
                .o_rec   (w_rec[g+1])
            );
        end
    endgenerate

    // title bar and close button test on the chosen window
    always_comb begin
        w_x    = 20'(signed'({1'b0, r_px}));
        w_y    = 20'(signed'({1'b0, r_py}));
        w_cs   = 20'(signed'({1'b0, r_cbs}));
        w_diff = 10'(signed'({2'b0, r_tbh})) - 10'(signed'({2'b0, r_cbs}));
        // halve toward zero
        w_off  = w_diff[9] ? -((-w_diff) >>> 1) : (w_diff >>> 1);
        w_bx   = 20'(signed'({1'b0, w_last.left})) + 20'(signed'({1'b0, w_last.width}))
                 - w_cs - 20'(CLOSE_MARGIN);
        w_by   = 20'(signed'({1'b0, w_last.top})) + 20'(w_off);
        w_in_x = ({1'b0, r_px} >= {1'b0, w_last.left})
                 && ({1'b0, r_px} < ({1'b0, w_last.left} + {1'b0, w_last.width}));
        w_tb   = w_in_x && ({1'b0, r_py} >= {1'b0, w_last.top})
                 && ({1'b0, r_py} < ({1'b0, w_last.top} + {9'b0, r_tbh}));
        w_cb   = w_last.cl && (w_x >= w_bx) && (w_x < (w_bx + w_cs))
                 && (w_y >= w_by) && (w_y < (w_by + w_cs));
    end

    always_comb begin
        w_ok     = w_last.hit;
        w_status = ST_EMPTY;
        w_rslot  = '0;
        w_id     = '0;
        w_lvl    = '0;
        w_count  = w_last.count;
        case (r_mode)
            MODE_CREATE: begin
                w_ok     = w_last.free;
                w_status = ST_FULL;
                if (w_ok) begin
                    w_status = ST_OK;
                    w_rslot  = w_last.free_slot;
                    w_id     = r_next_id;
                    w_lvl    = w_raise;
                    w_count  = w_last.count + CNT_W'(1);
                end
            end
            MODE_DESTROY: begin
                if (w_ok) begin
                    w_status = ST_OK;
                    w_rslot  = w_last.slot;
                    w_id     = w_last.id;
                    w_lvl    = w_last.lvl;
                    w_count  = w_last.count - CNT_W'(1);
                end
            end
            MODE_FOCUS: begin
                if (w_ok) begin
                    w_status = ST_OK;
                    w_rslot  = w_last.slot;
                    w_id     = w_last.id;
                    w_lvl    = w_raise;
                end
            end
            default: begin
                if (w_ok) begin
                    w_status = ST_OK;
                    w_rslot  = w_last.slot;
                    w_id     = w_last.id;
                    w_lvl    = w_last.lvl;
                end
            end
        endcase

        w_cmd.mode      = r_mode;
        w_cmd.slot      = r_slot;
        w_cmd.px        = r_px;
        w_cmd.py        = r_py;
        w_cmd.w         = r_w;
        w_cmd.h         = r_h;
        w_cmd.cl        = r_cl;
        w_cmd.commit    = w_done && w_ok && (r_mode != MODE_QUERY);
        w_cmd.new_level = w_raise;
        w_cmd.new_id    = r_next_id;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last.vld) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_next_id <= 32'd1;
            r_tbh     <= 8'd24;
            r_cbs     <= 8'd16;
        end else begin
            r_state <= n_state;
            r_go    <= w_accept;
            if (w_done && w_ok && (r_mode == MODE_CREATE)) begin
                r_next_id <= r_next_id + 32'd1;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TITLEBAR: r_tbh <= i_cfg.data;
                    REG_CLOSE:    r_cbs <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_in.mode;
            r_slot <= i_in.slot;
            r_px   <= i_in.pos_x;
            r_py   <= i_in.pos_y;
            r_w    <= i_in.width;
            r_h    <= i_in.height;
            r_cl   <= i_in.closable;
        end
        if (w_done) begin
            r_status <= w_status;
            r_rslot  <= w_rslot;
            r_id     <= w_id;
            r_lvl    <= w_lvl;
            r_tb     <= (r_mode == MODE_QUERY) && w_ok && w_tb;
            r_cb     <= (r_mode == MODE_QUERY) && w_ok && w_cb;
            r_count  <= w_count[4:0];
        end
    end

    assign o_out.valid           = (r_state == S_OUT);
    assign o_out.status          = r_status;
    assign o_out.result_slot     = r_rslot;
    assign o_out.window_id       = r_id;
    assign o_out.level           = r_lvl;
    assign o_out.on_titlebar     = r_tb;
    assign o_out.on_close_button = r_cb;
    assign o_out.window_count    = r_count;

    `WLTH_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, w_accept, (r_state == S_SCAN) && r_go)
    `WLTH_ASSERT_NOW(a_row_end_only_in_scan, i_clk, i_rst_n, w_last.vld, r_state == S_SCAN)
    `WLTH_ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, w_done, o_out.valid)
    `WLTH_ASSERT_NOW(a_no_commit_on_query, i_clk, i_rst_n, w_cmd.commit, r_mode != MODE_QUERY)

endmodule
